FILE: rtl/ucnesc_pkg.sv
package ucnesc_pkg;

    // pending window and result sizes
    localparam int WIN_DEPTH        = 9;
    localparam int MAX_EMIT         = 10;
    localparam int CNT_W            = 4;

    // positions inside a pending escape
    localparam int LONG_FINAL_POS   = 9;
    localparam int SHORT_FINAL_POS  = 5;
    localparam int LONG_ZERO_END    = 6;
    localparam int SHORT_ZERO_END   = 4;
    localparam int SHORT_LETTER_POS = 4;
    localparam int LONG_QUAD_POS    = 6;

    localparam int QUEUE_DEPTH_DEF  = 4;

    // characters of interest
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BIG_U   = 8'h55;
    localparam logic [7:0] CH_SMALL_U = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // one queue entry: the bytes caused by one input item
    typedef struct packed {
        logic [MAX_EMIT-1:0][7:0] bytes;
        logic [CNT_W-1:0]         cnt;
        logic                     last;
    } q_entry_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || is_letter(b);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = b[3:0];
        end
        else if (is_letter(b))
        begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

FILE: rtl/ucnesc_front.sv
module ucnesc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               q_full,
    output logic               push,
    output ucnesc_pkg::q_entry_t push_entry
);
    import ucnesc_pkg::*;

    logic [7:0]               win_reg  [WIN_DEPTH];
    logic [7:0]               win_next [WIN_DEPTH];
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     accept;
    logic                     kind_long;
    logic                     fit;
    logic                     brk;
    logic                     complete;
    logic [7:0]               letter;
    logic                     long_keeps_form;
    logic [MAX_EMIT-1:0][7:0] pass;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign kind_long = (win_reg[1] == CH_BIG_U);
    assign letter    = kind_long ? win_reg[WIN_DEPTH-1] : win_reg[SHORT_LETTER_POS];

    // does the new byte continue the pending escape
    always_comb
    begin
        fit = 1'b0;
        if (cnt_reg == 4'd1)
        begin
            fit = (in_byte == CH_BIG_U) || (in_byte == CH_SMALL_U);
        end
        else if (kind_long)
        begin
            fit = (cnt_reg < 4'(LONG_ZERO_END)) ? (in_byte == CH_ZERO) : is_hex(in_byte);
        end
        else if (cnt_reg < 4'(SHORT_ZERO_END))
        begin
            fit = (in_byte == CH_ZERO);
        end
        else if (cnt_reg == 4'(SHORT_LETTER_POS))
        begin
            fit = is_letter(in_byte);
        end
        else
        begin
            fit = is_hex(in_byte);
        end
    end

    assign brk      = (cnt_reg == '0) || !fit;
    assign complete = !brk && ((kind_long && cnt_reg == 4'(LONG_FINAL_POS)) ||
                               (!kind_long && cnt_reg == 4'(SHORT_FINAL_POS)));
    assign long_keeps_form = !(win_reg[LONG_QUAD_POS] == CH_ZERO &&
                               win_reg[LONG_QUAD_POS+1] == CH_ZERO &&
                               is_letter(win_reg[LONG_QUAD_POS+2]));

    // held bytes followed by the new byte
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            pass[i] = (4'(i) < cnt_reg) ? win_reg[i] : in_byte;
        end
        pass[MAX_EMIT-1] = in_byte;
    end

    always_comb
    begin
        push_entry.bytes = pass;
        push_entry.cnt   = cnt_reg + 4'd1;
        push_entry.last  = in_last;
        cnt_next         = cnt_reg;
        win_next         = win_reg;
        if (accept)
        begin
            if (complete)
            begin
                cnt_next = '0;
                if (kind_long && long_keeps_form)
                begin
                    // long form with a low code point shortens to the short form
                    push_entry.bytes[0] = CH_BSLASH;
                    push_entry.bytes[1] = CH_SMALL_U;
                    push_entry.bytes[2] = win_reg[LONG_QUAD_POS];
                    push_entry.bytes[3] = win_reg[LONG_QUAD_POS+1];
                    push_entry.bytes[4] = win_reg[LONG_QUAD_POS+2];
                    push_entry.bytes[5] = in_byte;
                    push_entry.cnt      = 4'd6;
                end
                else
                begin
                    push_entry.bytes[0] = {hex_val(letter), hex_val(in_byte)};
                    push_entry.cnt      = 4'd1;
                end
            end
            else if (brk)
            begin
                if (in_byte == CH_BSLASH && !in_last)
                begin
                    push_entry.cnt = cnt_reg;
                    cnt_next       = 4'd1;
                    win_next[0]    = in_byte;
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            else if (in_last)
            begin
                cnt_next = '0;
            end
            else
            begin
                push_entry.cnt    = '0;
                cnt_next          = cnt_reg + 4'd1;
                win_next[cnt_reg] = in_byte;
            end
        end
    end

    assign push = accept && (push_entry.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(WIN_DEPTH))
        else $error("pending count beyond window");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> push)
        else $error("end of text produced no bytes");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> cnt_reg == '0)
        else $error("window not empty after end of text");

endmodule

FILE: rtl/ucnesc_fifo.sv
module ucnesc_fifo #(
    parameter int DEPTH = ucnesc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ucnesc_pkg::q_entry_t push_entry,
    output logic                 full,
    output logic                 valid,
    output ucnesc_pkg::q_entry_t head,
    input  logic                 pop
);
    import ucnesc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign full  = (occ_reg == OCC_W'(DEPTH));
    assign valid = (occ_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

endmodule

FILE: rtl/ucnesc_back.sv
module ucnesc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ucnesc_pkg::q_entry_t q_head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 out_last
);
    import ucnesc_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic             load;
    logic             at_end;

    assign load   = !out_valid_reg || !out_stall;
    assign at_end = (idx_reg == q_head.cnt - 4'd1);
    assign pop    = load && q_valid && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                out_byte_next = q_head.bytes[idx_reg];
                out_last_next = q_head.last && at_end;
                idx_next      = at_end ? '0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> idx_reg < q_head.cnt)
        else $error("byte index past end of queue entry");

endmodule

FILE: rtl/ucn_escape_shortener_top.sv
// escape shortener for a stream of source text bytes
// input channel: in_valid / in_stall with in_byte and in_last (last byte of the text)
// output channel: out_valid / out_stall with out_byte and out_last (last rewritten byte)
// "\U0000" plus four hex digits becomes "\u" plus the digits; "\u00" or "\U000000"
// plus a hex letter and a hex digit becomes the single byte 0xa0-0xff; anything
// else passes through, and a broken escape is replayed as it came in
// throughput: one item per cycle on the input while the queue has room; the output
// runs at one byte per cycle while out_stall is low, and one item causes 0 to 10 bytes
// with the queue empty, an accepted item is written into the queue and its first byte
// is then loaded into the output register; escape bytes wait in the window until
// the escape is decided
// the front scanner, the entry queue and the byte sequencer run decoupled: a
// stalled receiver holds the output register, the queue fills, and then in_stall
// rises and holds the input until an entry is drained
// reset clears the pending count, empties the queue and drops out_valid; the
// window bytes themselves are not cleared
module ucn_escape_shortener_top #(
    parameter int QUEUE_DEPTH = ucnesc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import ucnesc_pkg::*;

    // front to queue
    logic     push;
    q_entry_t push_entry;
    logic     q_full;

    // queue to back
    logic     q_valid;
    q_entry_t q_head;
    logic     pop;

    // scanner: holds the pending window and decides each item at once
    ucnesc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue of per-item byte groups
    ucnesc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head),
        .pop        (pop)
    );

    // sequencer: walks each group one byte per cycle, while the output is not stalled, into the output register
    ucnesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule
